// ----- design/nmea_rmc_pkg.sv -----
package nmea_rmc_pkg;

    // Character and text buffer geometry
    localparam int CHAR_W     = 8;
    localparam int TEXT_DEPTH = 24;
    localparam int TEXT_AW    = 5;
    localparam int FIELD_CNT  = 4;
    localparam int LEN_W      = 4;
    localparam int HDR_LEN    = 6;
    localparam int MIN_TOKENS = 7;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CHAR_NUL   = 8'h00;
    localparam char_t CHAR_COMMA = 8'h2C;
    localparam char_t CHAR_A     = 8'h41;
    localparam char_t CHAR_SPACE = 8'h20;

    // Expected sentence header "$GPRMC"
    function automatic char_t hdr_char(input logic [2:0] idx);
        char_t c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // Start of each coordinate field in the text buffer
    function automatic logic [TEXT_AW-1:0] field_off(input logic [1:0] f);
        logic [TEXT_AW-1:0] o;
        case (f)
            2'd0:    o = 5'd0;
            2'd1:    o = 5'd10;
            2'd2:    o = 5'd12;
            2'd3:    o = 5'd22;
            default: o = 5'd0;
        endcase
        return o;
    endfunction

    // Characters kept per field: 10 for coordinates, 2 for hemispheres
    function automatic logic [LEN_W-1:0] field_lim(input logic [1:0] f);
        return f[0] ? 4'd2 : 4'd10;
    endfunction

    typedef struct packed {
        logic take;     // parse the byte of this input transfer
        logic last;     // this byte closes the read, arm the emit sequence
        logic fetch;    // read current character from the text buffer
        logic skip;     // current segment is exhausted, move on
        logic put;      // load the output register, advance
    } dp_cmd_t;

    typedef struct packed {
        logic item_here;    // current segment has a result to send
        logic out_free;     // output register can take a result
        logic final_item;   // current result ends the run
    } dp_stat_t;

endpackage

// ----- design/nmea_rmc_in_if.sv -----
interface nmea_rmc_in_if;
    logic                  valid;
    logic                  ready;
    nmea_rmc_pkg::char_t   rx_byte;
    logic                  end_of_read;

    modport source (output valid, rx_byte, end_of_read, input ready);
    modport sink   (input valid, rx_byte, end_of_read, output ready);
endinterface

// ----- design/nmea_rmc_out_if.sv -----
interface nmea_rmc_out_if;
    logic                  valid;
    logic                  ready;
    logic                  fix_valid;
    logic                  text_select;
    nmea_rmc_pkg::char_t   text_char;
    logic                  run_last;

    modport source (output valid, fix_valid, text_select, text_char, run_last, input ready);
    modport sink   (input valid, fix_valid, text_select, text_char, run_last, output ready);
endinterface

// ----- design/nmea_rmc_ctrl.sv -----
module nmea_rmc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    output nmea_rmc_pkg::dp_cmd_t  cmd,
    input  nmea_rmc_pkg::dp_stat_t stat
);

    typedef enum logic [1:0] {
        S_PARSE,
        S_FETCH,
        S_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_PARSE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_last)
                    begin
                        cmd.last   = 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (stat.item_here)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.skip = 1'b1;
                end
            end
            S_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = stat.final_item ? S_PARSE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_PARSE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_PARSE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/nmea_rmc_dp.sv -----
module nmea_rmc_dp #(
    parameter int MAX_TOKENS  = 15,
    parameter int TOKEN_CHARS = 19
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nmea_rmc_pkg::char_t    in_byte,
    input  nmea_rmc_pkg::dp_cmd_t  cmd,
    output nmea_rmc_pkg::dp_stat_t stat,
    nmea_rmc_out_if.source         fix
);

    localparam int TOK_W  = $clog2(MAX_TOKENS + 1);
    localparam int CPOS_W = $clog2(TOKEN_CHARS + 1);
    localparam int LEN_W  = nmea_rmc_pkg::LEN_W;
    localparam int AW     = nmea_rmc_pkg::TEXT_AW;

    // Emit segments: chars, space, chars per half
    localparam logic [2:0] SEG_F0  = 3'd0;
    localparam logic [2:0] SEG_SP0 = 3'd1;
    localparam logic [2:0] SEG_F1  = 3'd2;
    localparam logic [2:0] SEG_F2  = 3'd3;
    localparam logic [2:0] SEG_SP1 = 3'd4;
    localparam logic [2:0] SEG_F3  = 3'd5;

    // Parser state
    logic [TOK_W-1:0]   tok_reg;
    logic [CPOS_W-1:0]  cpos_reg;
    logic               inside_reg;
    logic               ended_reg;
    logic               hdr_ok_reg;
    logic               stat_a_reg;
    logic [LEN_W-1:0]   len_reg [nmea_rmc_pkg::FIELD_CNT];

    // Text buffer and emit sequencer
    nmea_rmc_pkg::char_t text_mem [nmea_rmc_pkg::TEXT_DEPTH];
    nmea_rmc_pkg::char_t rd_data_reg;
    logic [2:0]          seg_reg;
    logic [LEN_W-1:0]    idx_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_fix_reg;
    logic                out_sel_reg;
    nmea_rmc_pkg::char_t out_char_reg;
    logic                out_last_reg;

    // Byte decode
    logic               open_tok;
    logic               tok_full;
    logic [TOK_W-1:0]   tok_cur;
    logic [TOK_W-1:0]   tok_num;
    logic [CPOS_W-1:0]  pos;
    logic               is_nul;
    logic               is_comma;
    logic               is_char;
    logic               in_field;
    logic [1:0]         wr_field;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               hdr_bad_char;
    logic               hdr_bad_comma;

    // Emit decode
    logic               fix_ok;
    logic               seg_space;
    logic [1:0]         seg_field;
    logic [LEN_W-1:0]   cur_len;
    logic [AW-1:0]      rd_addr;
    logic               item_here;
    logic               final_item;

    always_comb
    begin
        open_tok  = !inside_reg;
        tok_full  = tok_reg >= TOK_W'(MAX_TOKENS);
        tok_cur   = open_tok ? tok_reg + TOK_W'(1) : tok_reg;
        tok_num   = tok_cur - TOK_W'(1);
        pos       = open_tok ? '0 : cpos_reg;
        is_nul    = in_byte == nmea_rmc_pkg::CHAR_NUL;
        is_comma  = in_byte == nmea_rmc_pkg::CHAR_COMMA;
        is_char   = !ended_reg && !is_nul && !is_comma && !(open_tok && tok_full);
        in_field  = tok_num >= TOK_W'(3) && tok_num <= TOK_W'(6);
        wr_field  = 2'(tok_num - TOK_W'(3));
        wr_en     = is_char && in_field
                    && (pos < CPOS_W'(nmea_rmc_pkg::field_lim(wr_field)));
        wr_addr   = nmea_rmc_pkg::field_off(wr_field) + AW'(pos);
        hdr_bad_char  = (pos >= CPOS_W'(nmea_rmc_pkg::HDR_LEN))
                        || (in_byte != nmea_rmc_pkg::hdr_char(pos[2:0]));
        hdr_bad_comma = inside_reg && (tok_reg == TOK_W'(1))
                        && (cpos_reg != CPOS_W'(nmea_rmc_pkg::HDR_LEN));
    end

    always_comb
    begin
        fix_ok    = hdr_ok_reg && stat_a_reg
                    && (tok_reg >= TOK_W'(nmea_rmc_pkg::MIN_TOKENS));
        seg_space = (seg_reg == SEG_SP0) || (seg_reg == SEG_SP1);
        case (seg_reg)
            SEG_F0:  seg_field = 2'd0;
            SEG_F1:  seg_field = 2'd1;
            SEG_F2:  seg_field = 2'd2;
            SEG_F3:  seg_field = 2'd3;
            default: seg_field = 2'd0;
        endcase
        cur_len    = len_reg[seg_field];
        rd_addr    = nmea_rmc_pkg::field_off(seg_field) + AW'(idx_reg);
        item_here  = !fix_ok || seg_space || (idx_reg < cur_len);
        final_item = !fix_ok
                     || ((seg_reg == SEG_F3) && ((idx_reg + LEN_W'(1)) == len_reg[3]))
                     || ((seg_reg == SEG_SP1) && (len_reg[3] == '0));
    end

    assign stat.item_here  = item_here;
    assign stat.final_item = final_item;
    assign stat.out_free   = !out_valid_reg || fix.ready;

    // Parser and emit control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            cpos_reg   <= '0;
            inside_reg <= 1'b0;
            ended_reg  <= 1'b0;
            hdr_ok_reg <= 1'b1;
            stat_a_reg <= 1'b0;
            for (int i = 0; i < nmea_rmc_pkg::FIELD_CNT; i++)
            begin
                len_reg[i] <= '0;
            end
            seg_reg    <= SEG_F0;
            idx_reg    <= '0;
        end
        else
        begin
            // per-read clear once the run is out
            if (cmd.put && final_item)
            begin
                tok_reg    <= '0;
                cpos_reg   <= '0;
                inside_reg <= 1'b0;
                ended_reg  <= 1'b0;
                hdr_ok_reg <= 1'b1;
                stat_a_reg <= 1'b0;
                for (int i = 0; i < nmea_rmc_pkg::FIELD_CNT; i++)
                begin
                    len_reg[i] <= '0;
                end
            end
            else if (cmd.take && !ended_reg)
            begin
                if (is_nul)
                begin
                    ended_reg  <= 1'b1;
                    inside_reg <= 1'b0;
                end
                else if (is_comma)
                begin
                    if (hdr_bad_comma)
                    begin
                        hdr_ok_reg <= 1'b0;
                    end
                    inside_reg <= 1'b0;
                end
                else if (is_char)
                begin
                    tok_reg    <= tok_cur;
                    inside_reg <= 1'b1;
                    if (tok_num == TOK_W'(0) && hdr_bad_char)
                    begin
                        hdr_ok_reg <= 1'b0;
                    end
                    if (tok_num == TOK_W'(2) && pos == '0)
                    begin
                        stat_a_reg <= in_byte == nmea_rmc_pkg::CHAR_A;
                    end
                    if (wr_en)
                    begin
                        len_reg[wr_field] <= LEN_W'(pos) + LEN_W'(1);
                    end
                    cpos_reg <= (pos < CPOS_W'(TOKEN_CHARS)) ? pos + CPOS_W'(1) : pos;
                end
            end

            // emit sequencer
            if (cmd.last)
            begin
                seg_reg <= SEG_F0;
                idx_reg <= '0;
            end
            else if (cmd.skip || (cmd.put && seg_space))
            begin
                seg_reg <= seg_reg + 3'd1;
                idx_reg <= '0;
            end
            else if (cmd.put)
            begin
                idx_reg <= idx_reg + LEN_W'(1);
            end
        end
    end

    // Text buffer: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.take && !ended_reg && wr_en)
        begin
            text_mem[wr_addr] <= in_byte;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= text_mem[rd_addr];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (fix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            out_fix_reg  <= fix_ok;
            out_sel_reg  <= fix_ok && (seg_reg >= SEG_F2);
            out_char_reg <= !fix_ok ? nmea_rmc_pkg::CHAR_NUL
                          : seg_space ? nmea_rmc_pkg::CHAR_SPACE : rd_data_reg;
            out_last_reg <= final_item;
        end
    end

    assign fix.valid       = out_valid_reg;
    assign fix.fix_valid   = out_fix_reg;
    assign fix.text_select = out_sel_reg;
    assign fix.text_char   = out_char_reg;
    assign fix.run_last    = out_last_reg;

endmodule

// ----- design/nmea_rmc_position_extractor_unit.sv -----
// RMC position extractor. Takes the bytes of one serial read on rx, one per
// transfer, with end_of_read on the final byte. Bytes are split into comma
// separated tokens (empty tokens collapse, a zero byte ends the text, at most
// MAX_TOKENS tokens count, tokens truncate at TOKEN_CHARS characters). After
// the final byte the block sends a run on fix: for a "$GPRMC" sentence with
// status 'A' and at least 7 tokens, up to 10 characters of the latitude, a
// space and up to 2 hemisphere characters (text_select 0), then the same for
// longitude (text_select 1); otherwise one result with fix_valid 0. run_last
// marks the end of a run. Rate: rx takes one byte per cycle while parsing.
// During a run rx is held off; each result is a text buffer read, then an
// output register load. A coordinate run also takes a skip step past the end
// of each of its first three fields, empty or not. Any stall on fix holds
// the run. The last result waits in the output register while the next read
// is taken.
module nmea_rmc_position_extractor_unit #(
    parameter int MAX_TOKENS  = 15,
    parameter int TOKEN_CHARS = 19
) (
    input  logic            clk,
    input  logic            rst_n,
    nmea_rmc_in_if.sink     rx,
    nmea_rmc_out_if.source  fix
);

    nmea_rmc_pkg::dp_cmd_t  cmd;
    nmea_rmc_pkg::dp_stat_t stat;
    logic                   in_ready;

    assign rx.ready = in_ready;

    nmea_rmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_last  (rx.end_of_read),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    nmea_rmc_dp #(
        .MAX_TOKENS  (MAX_TOKENS),
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (rx.rx_byte),
        .cmd     (cmd),
        .stat    (stat),
        .fix     (fix)
    );

    // An invalid result is always a single-result run with a zero character
    a_invalid_single : assert property (@(posedge clk) disable iff (!rst_n)
        fix.valid && !fix.fix_valid |-> fix.run_last && fix.text_char == 8'h00)
        else $error("invalid result not a lone zero result");

    // The final byte of a read stops input until the last result is loaded
    a_hold_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready && rx.end_of_read |=> !rx.ready)
        else $error("input taken right after end of read");

    // Input stays closed while a run is still in progress
    a_hold_in_run : assert property (@(posedge clk) disable iff (!rst_n)
        fix.valid && !fix.run_last |-> !rx.ready)
        else $error("input open in the middle of a run");

endmodule
